// File: hdl/sid_pkg.sv
// shared types, constants and address mapping for the screen image depacker
package sid_pkg;

    // image store geometry
    localparam int STORE_DEPTH = 6912;
    localparam logic [12:0] STORE_SIZE = 13'd6912;
    localparam logic [12:0] PIX_SIZE = 13'd6144;
    localparam logic [7:0] ATTR_FILL = 8'h07;

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_STATUS = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_SIZE = 2'd1;
    localparam logic [1:0] ERR_ADDR = 2'd2;
    localparam logic [1:0] ERR_BYTE = 2'd3;

    // token constants
    localparam logic [7:0] TOK_END = 8'hC0;
    localparam logic [7:0] TOK_CLASS_MASK = 8'hC1;
    localparam logic [7:0] TOK_FILL = 8'hC1;
    localparam logic [7:0] TOK_LIT = 8'hC0;
    localparam logic [12:0] LIMIT_FLIP = 13'h1800;
    localparam logic [12:0] LIMIT_MASK = 13'h1C00;
    localparam logic [15:0] CONSUMED_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  data_byte;
        logic [12:0] read_address;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        done_res;
        logic [1:0]  error_code;
        logic        pixels_only;
        logic [15:0] bytes_consumed;
    } out_item_t;

    // follow-up work that a step asks of the controller
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FILL  = 2'd2,
        OP_COPY  = 2'd3
    } op_t;

    typedef struct packed {
        logic latch;
        logic step;
        logic clear;
        logic fill;
        logic cp_rd;
        logic cp_wr;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  next_op;
        logic clear_last;
        logic run_last;
    } dp_status_t;

    // virtual write address to store address, 17 bits so overflow is visible
    function automatic logic [16:0] map_addr(input logic [15:0] v,
                                             input logic [12:0] limit,
                                             input logic [12:0] base);
        logic [16:0] res;
        if (v < {3'b000, limit}) begin
            res = {4'b0000, v[12:11], v[2:0], v[5:3], v[10:6]};
        end else begin
            res = {4'b0000, base} + {1'b0, v};
        end
        return res;
    endfunction

    // legal size codes
    function automatic logic size_ok(input logic [7:0] b);
        return (b == 8'd0) || (b == 8'd1) || (b == 8'd2) ||
               (b == 8'd8) || (b == 8'd9) || (b == 8'd16);
    endfunction

endpackage

// File: hdl/sid_ctrl.sv
// sequencing state machine for the screen image depacker
module sid_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output sid_pkg::ctrl_cmd_t cmd,
    input  sid_pkg::dp_status_t sts
);
    import sid_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_STEP  = 7'b0000010,
        ST_CLEAR = 7'b0000100,
        ST_FILL  = 7'b0001000,
        ST_CPRD  = 7'b0010000,
        ST_CPWR  = 7'b0100000,
        ST_RESP  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   clear_resp_reg, clear_resp_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next      = state_reg;
        clear_resp_next = clear_resp_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.latch = accept;
                if (accept) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                unique case (sts.next_op)
                    OP_CLEAR: begin
                        state_next      = ST_CLEAR;
                        clear_resp_next = 1'b1;
                    end
                    OP_FILL: state_next = ST_FILL;
                    OP_COPY: state_next = ST_CPRD;
                    default: state_next = ST_RESP;
                endcase
            end
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next      = clear_resp_reg ? ST_RESP : ST_IDLE;
                    clear_resp_next = 1'b0;
                end
            end
            ST_FILL: begin
                cmd.fill = 1'b1;
                if (sts.run_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_CPRD: begin
                cmd.cp_rd  = 1'b1;
                state_next = sts.run_last ? ST_RESP : ST_CPWR;
            end
            ST_CPWR: begin
                cmd.cp_wr  = 1'b1;
                state_next = sts.run_last ? ST_RESP : ST_CPRD;
            end
            ST_RESP: begin
                cmd.out_load = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // state registers, reset starts with a clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clear_resp_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clear_resp_reg <= clear_resp_next;
            m_valid_reg    <= m_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // a result appears only out of the response state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside response state");

    // a copy write always follows its source read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CPWR) |-> $past(state_reg == ST_CPRD))
        else $error("copy write without source read");

    // an accepted transfer is decoded in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_STEP))
        else $error("accepted transfer not stepped");
`endif

endmodule

// File: hdl/sid_datapath.sv
// parser registers, image store and result register of the screen image depacker
module sid_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  sid_pkg::in_item_t   s_item,
    input  sid_pkg::ctrl_cmd_t  cmd,
    output sid_pkg::dp_status_t sts,
    output sid_pkg::out_item_t  m_item
);
    import sid_pkg::*;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b00000001,
        PH_SIZE  = 8'b00000010,
        PH_TOKEN = 8'b00000100,
        PH_FLEN  = 8'b00001000,
        PH_FVAL  = 8'b00010000,
        PH_LIT   = 8'b00100000,
        PH_CEXT  = 8'b01000000,
        PH_CLO   = 8'b10000000
    } phase_t;

    logic [7:0] mem_ram [0:STORE_DEPTH-1];

    in_item_t    item_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] wp_reg, wp_next;
    logic [12:0] base_reg, base_next;
    logic [12:0] limit_reg, limit_next;
    logic [7:0]  token_reg, token_next;
    logic [8:0]  run_reg, run_next;
    logic [7:0]  offh_reg, offh_next;
    logic        done_reg, done_next;
    logic [1:0]  err_reg, err_next;
    logic [15:0] consumed_reg, consumed_next;
    logic [7:0]  fill_val_reg, fill_val_next;
    logic [15:0] src_reg, src_next;
    logic [12:0] dst_reg, dst_next;
    logic [12:0] clr_addr_reg, clr_addr_next;
    logic [7:0]  rdata_reg;
    out_item_t   out_reg;

    logic        mem_we, mem_re;
    logic [12:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata;
    logic [16:0] map_wp, map_src;
    logic        wp_ok, src_ok;
    logic [7:0]  b;
    logic [12:0] size_base;

    assign b         = item_reg.data_byte;
    assign map_wp    = map_addr(wp_reg, limit_reg, base_reg);
    assign map_src   = map_addr(src_reg, limit_reg, base_reg);
    assign wp_ok     = map_wp < {4'b0000, STORE_SIZE};
    assign src_ok    = map_src < {4'b0000, STORE_SIZE};
    assign size_base = {b[4:0], 8'h00};

    // step decode, runs and clearing sweep
    always_comb begin
        phase_next    = phase_reg;
        wp_next       = wp_reg;
        base_next     = base_reg;
        limit_next    = limit_reg;
        token_next    = token_reg;
        run_next      = run_reg;
        offh_next     = offh_reg;
        done_next     = done_reg;
        err_next      = err_reg;
        consumed_next = consumed_reg;
        fill_val_next = fill_val_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        clr_addr_next = clr_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = map_wp[12:0];
        mem_wdata     = b;
        mem_re        = 1'b0;
        mem_raddr     = map_src[12:0];
        sts           = '{next_op: OP_NONE, clear_last: 1'b0, run_last: 1'b0};

        // clearing sweep, one entry a cycle
        if (cmd.clear) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = (clr_addr_reg < PIX_SIZE) ? 8'h00 : ATTR_FILL;
            if (clr_addr_reg == STORE_SIZE - 13'd1) begin
                clr_addr_next  = '0;
                sts.clear_last = 1'b1;
            end else begin
                clr_addr_next = clr_addr_reg + 13'd1;
            end
        end

        // one accepted item
        if (cmd.step) begin
            unique case (item_reg.command)
                CMD_START: begin
                    phase_next    = PH_SIZE;
                    wp_next       = '0;
                    base_next     = '0;
                    limit_next    = '0;
                    token_next    = '0;
                    run_next      = '0;
                    offh_next     = '0;
                    done_next     = 1'b0;
                    err_next      = ERR_NONE;
                    consumed_next = '0;
                    sts.next_op   = OP_CLEAR;
                end
                CMD_BYTE: begin
                    if (phase_reg == PH_IDLE) begin
                        if (err_reg == ERR_NONE) begin
                            err_next = ERR_BYTE;
                        end
                    end else begin
                        if (consumed_reg != CONSUMED_MAX) begin
                            consumed_next = consumed_reg + 16'd1;
                        end
                        unique case (phase_reg)
                            PH_SIZE: begin
                                if (size_ok(b)) begin
                                    base_next  = size_base;
                                    limit_next = (size_base ^ LIMIT_FLIP) & LIMIT_MASK;
                                    wp_next    = {3'b000, b[1:0], 11'd0};
                                    phase_next = PH_TOKEN;
                                end else begin
                                    err_next   = ERR_SIZE;
                                    phase_next = PH_IDLE;
                                end
                            end
                            PH_TOKEN: begin
                                token_next = b;
                                if (b == TOK_END) begin
                                    done_next  = 1'b1;
                                    phase_next = PH_IDLE;
                                end else if ((b & TOK_CLASS_MASK) == TOK_FILL) begin
                                    // fill run, bit 1 clear takes a fill value byte
                                    if (b[5:2] == 4'd0) begin
                                        phase_next = PH_FLEN;
                                    end else begin
                                        run_next = {5'd0, b[5:2]} + {8'd0, !b[1]};
                                        if (!b[1]) begin
                                            phase_next = PH_FVAL;
                                        end else begin
                                            fill_val_next = 8'h00;
                                            sts.next_op   = OP_FILL;
                                        end
                                    end
                                end else if ((b & TOK_CLASS_MASK) == TOK_LIT) begin
                                    run_next   = (b[5:1] == 5'd0) ? 9'd256
                                                                  : {4'd0, b[5:1]};
                                    phase_next = PH_LIT;
                                end else begin
                                    // back-reference
                                    offh_next = {5'b11111, b[2:0]};
                                    if (b[6:3] == 4'd0) begin
                                        phase_next = PH_CEXT;
                                    end else begin
                                        run_next   = {5'd0, b[6:3]} + 9'd1;
                                        phase_next = PH_CLO;
                                    end
                                end
                            end
                            PH_FLEN: begin
                                run_next = (b == 8'd0) ? 9'd256 : {1'b0, b};
                                if (!token_reg[1]) begin
                                    phase_next = PH_FVAL;
                                end else begin
                                    fill_val_next = 8'h00;
                                    sts.next_op   = OP_FILL;
                                end
                            end
                            PH_FVAL: begin
                                fill_val_next = b;
                                sts.next_op   = OP_FILL;
                            end
                            PH_LIT: begin
                                wp_next = wp_reg + 16'd1;
                                if (!wp_ok) begin
                                    err_next   = ERR_ADDR;
                                    phase_next = PH_IDLE;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_wdata = b;
                                    run_next  = run_reg - 9'd1;
                                    if (run_reg == 9'd1) begin
                                        phase_next = PH_TOKEN;
                                    end
                                end
                            end
                            PH_CEXT: begin
                                offh_next  = {offh_reg[6:0], b[0]};
                                run_next   = {2'b00, b[7:1]} + 9'd1;
                                phase_next = PH_CLO;
                            end
                            PH_CLO: begin
                                src_next    = wp_reg + {offh_reg, b};
                                sts.next_op = OP_COPY;
                            end
                            default: ;
                        endcase
                    end
                end
                CMD_READ: begin
                    mem_re    = (item_reg.read_address < STORE_SIZE);
                    mem_raddr = item_reg.read_address;
                end
                default: ;
            endcase
        end

        // fill run, one byte a cycle
        if (cmd.fill) begin
            wp_next = wp_reg + 16'd1;
            if (!wp_ok) begin
                err_next     = ERR_ADDR;
                phase_next   = PH_IDLE;
                sts.run_last = 1'b1;
            end else begin
                mem_we    = 1'b1;
                mem_wdata = fill_val_reg;
                run_next  = run_reg - 9'd1;
                if (run_reg == 9'd1) begin
                    phase_next   = PH_TOKEN;
                    sts.run_last = 1'b1;
                end
            end
        end

        // copy source read
        if (cmd.cp_rd) begin
            wp_next = wp_reg + 16'd1;
            if (!wp_ok || !src_ok) begin
                err_next     = ERR_ADDR;
                phase_next   = PH_IDLE;
                sts.run_last = 1'b1;
            end else begin
                mem_re   = 1'b1;
                dst_next = map_wp[12:0];
            end
        end

        // copy destination write, source steps by direction bit
        if (cmd.cp_wr) begin
            mem_we    = 1'b1;
            mem_waddr = dst_reg;
            mem_wdata = rdata_reg;
            src_next  = token_reg[7] ? (src_reg - 16'd1) : (src_reg + 16'd1);
            run_next  = run_reg - 9'd1;
            if (run_reg == 9'd1) begin
                phase_next   = PH_TOKEN;
                sts.run_last = 1'b1;
            end
        end
    end

    // image store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_ram[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem_ram[mem_raddr];
        end
    end

    // item and run payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_reg <= s_item;
        end
        fill_val_reg <= fill_val_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        if (cmd.out_load) begin
            out_reg.read_data      <= ((item_reg.command == CMD_READ) &&
                                       (item_reg.read_address < STORE_SIZE))
                                      ? rdata_reg : 8'h00;
            out_reg.done_res       <= done_reg;
            out_reg.error_code     <= err_reg;
            out_reg.pixels_only    <= done_reg && (wp_reg <= {3'b000, PIX_SIZE});
            out_reg.bytes_consumed <= consumed_reg;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            wp_reg       <= '0;
            base_reg     <= '0;
            limit_reg    <= '0;
            token_reg    <= '0;
            run_reg      <= '0;
            offh_reg     <= '0;
            done_reg     <= 1'b0;
            err_reg      <= ERR_NONE;
            consumed_reg <= '0;
            clr_addr_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            wp_reg       <= wp_next;
            base_reg     <= base_next;
            limit_reg    <= limit_next;
            token_reg    <= token_next;
            run_reg      <= run_next;
            offh_reg     <= offh_next;
            done_reg     <= done_next;
            err_reg      <= err_next;
            consumed_reg <= consumed_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign m_item = out_reg;

`ifndef ASSERT_OFF
    // every store write lands inside the image
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_waddr < STORE_SIZE))
        else $error("store write outside image");

    // a fill or copy step never runs with an empty count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fill || cmd.cp_wr) |-> (run_reg != 9'd0))
        else $error("run step with zero count");

    // consumed count only grows, except on a start
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(cmd.step && (item_reg.command == CMD_START)))
        |-> (consumed_reg >= $past(consumed_reg)))
        else $error("consumed count went back");
`endif

endmodule

// File: hdl/screen_image_depacker.sv
// top level of the screen image depacker
// Streaming depacker for a compressed 6912-byte screen image (6144 interleaved
// pixel bytes, then 768 attribute bytes). Each input transfer carries one
// command: start a new image, feed one compressed byte, read one image byte,
// or query status; each gives exactly one result transfer with the status
// after it. Sequencing per item, set by the sequencer and the single write and
// single read port of the image store: a status, read or plain compressed
// byte is decoded in the cycle after acceptance and its result is loaded in
// the response state once the output register is free, and the next item is
// taken only after that; a fill run adds one store write per byte;
// a back-reference copy adds a read then a write per byte;
// a start adds a clearing pass of the store.
// After reset the block runs the same clearing pass before s_ready first
// rises. A finished result sits in an output register, so the next item is
// taken while it waits for m_ready.
module screen_image_depacker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sid_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output sid_pkg::out_item_t m_item
);
    import sid_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // sequencer
    sid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // parser, image store and result register
    sid_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_item  (m_item)
    );

endmodule
